// ===== hdl/tcps_pkg.sv =====
package tcps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;
   localparam int ID_BITS     = 16;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS    = IDX_BITS + 1;
   localparam int COUNT_BITS  = FILL_BITS;

   typedef enum logic [1:0] {
      CLS_IDLE = 2'd0,
      CLS_LOW  = 2'd1,
      CLS_HIGH = 2'd2
   } cls_type;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_ARRIVE = 1'b1;

   typedef struct packed {
      logic                 op;
      logic                 is_high;
      logic [TIME_BITS-1:0] service_time;
      logic [ID_BITS-1:0]   job_id;
   } req_type;

   typedef struct packed {
      logic                  done_res;
      logic [ID_BITS-1:0]    done_id;
      logic                  done_high;
      logic                  preempted;
      logic                  dropped;
      logic [1:0]            serving;
      logic [COUNT_BITS-1:0] high_count;
      logic [COUNT_BITS-1:0] low_count;
   } rsp_type;

   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] stime;
   } fifo_ctl_type;

   typedef struct packed {
      logic [FILL_BITS-1:0] fill;
      logic [FILL_BITS-1:0] fill_next;
      logic [ID_BITS-1:0]   head_id;
      logic [TIME_BITS-1:0] next_time;
   } fifo_stat_type;

endpackage

// ===== hdl/tcps_fifo.sv =====
module tcps_fifo
   import tcps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  fifo_ctl_type  ctl,
   output fifo_stat_type stat
);

   logic [ID_BITS-1:0]   ids_ff   [QUEUE_DEPTH];
   logic [TIME_BITS-1:0] times_ff [QUEUE_DEPTH];
   logic [IDX_BITS-1:0]  head_ff, head_in, head_inc, slot;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic [SUM_BITS-1:0]  slot_sum;

   always_comb begin
      head_inc = (head_ff == IDX_BITS'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      slot_sum = SUM_BITS'(head_ff) + SUM_BITS'(fill_ff);
      if (slot_sum >= SUM_BITS'(QUEUE_DEPTH)) begin
         slot = IDX_BITS'(slot_sum - SUM_BITS'(QUEUE_DEPTH));
      end else begin
         slot = IDX_BITS'(slot_sum);
      end
      head_in = ctl.pop ? head_inc : head_ff;
      fill_in = fill_ff;
      if (ctl.push) begin
         fill_in = fill_ff + 1'b1;
      end else if (ctl.pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
      if (ctl.push) begin
         ids_ff[slot]   <= ctl.id;
         times_ff[slot] <= ctl.stime;
      end
   end

   always_comb begin
      stat.fill      = fill_ff;
      stat.fill_next = fill_in;
      stat.head_id   = ids_ff[head_ff];
      if (ctl.push && fill_ff == '0) begin
         stat.next_time = ctl.stime;
      end else begin
         stat.next_time = times_ff[head_in];
      end
   end

endmodule

// ===== hdl/two_class_preemptive_scheduler.sv =====
// channel   ports                 direction  moves
// request   start, busy, req      in         one tick or one job arrival
// result    rsp_valid, rsp        out        one status record per request
//
// A request is registered on the edge that accepts it; its result is
// registered in the cycle after and shown for one cycle. busy stays low, so a
// request can enter every cycle.
// Synchronous reset empties both queues and idles the server.
// The result side has no stall.
module two_class_preemptive_scheduler
   import tcps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    rsp_valid,
   output rsp_type rsp
);

   logic                 req_valid_ff;
   req_type              req_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;
   cls_type              cls_ff, cls_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in, stime;
   fifo_ctl_type         hctl, lctl;
   fifo_stat_type        hstat, lstat;
   logic                 act_high, act_low, active, tick, arrive;
   logic                 done, hfull, lfull, hpush, lpush, restart;

   assign busy = 1'b0;

   always_comb begin
      act_high = (cls_ff == CLS_HIGH);
      act_low  = (cls_ff == CLS_LOW);
      active   = act_high || act_low;
      tick     = req_valid_ff && (req_ff.op == OP_TICK);
      arrive   = req_valid_ff && (req_ff.op == OP_ARRIVE);
      stime    = (req_ff.service_time == '0) ? TIME_BITS'(1) : req_ff.service_time;
      hfull    = (hstat.fill == FILL_BITS'(QUEUE_DEPTH));
      lfull    = (lstat.fill == FILL_BITS'(QUEUE_DEPTH));
      done     = tick && active && (rem_ff <= TIME_BITS'(1));
      hpush    = arrive && req_ff.is_high && !hfull;
      lpush    = arrive && !req_ff.is_high && !lfull;
      restart  = done || (hpush && !act_high) || (lpush && !active);

      hctl.push  = hpush;
      hctl.pop   = done && act_high;
      hctl.id    = req_ff.job_id;
      hctl.stime = stime;
      lctl.push  = lpush;
      lctl.pop   = done && act_low;
      lctl.id    = req_ff.job_id;
      lctl.stime = stime;

      cls_in = cls_ff;
      rem_in = rem_ff;
      if (restart) begin
         if (hstat.fill_next != '0) begin
            cls_in = CLS_HIGH;
            rem_in = hstat.next_time;
         end else if (lstat.fill_next != '0) begin
            cls_in = CLS_LOW;
            rem_in = lstat.next_time;
         end else begin
            cls_in = CLS_IDLE;
            rem_in = '0;
         end
      end else if (tick && active) begin
         rem_in = rem_ff - 1'b1;
      end

      rsp_in.done_res   = done;
      rsp_in.done_high  = done && act_high;
      rsp_in.done_id    = !done ? '0 : (act_high ? hstat.head_id : lstat.head_id);
      rsp_in.preempted  = hpush && act_low;
      rsp_in.dropped    = arrive && (req_ff.is_high ? hfull : lfull);
      rsp_in.serving    = (cls_in == CLS_HIGH || cls_in == CLS_LOW) ? cls_in : CLS_IDLE;
      rsp_in.high_count = COUNT_BITS'(hstat.fill_next);
      rsp_in.low_count  = COUNT_BITS'(lstat.fill_next);
   end

   tcps_fifo u_high (
      .clock (clock),
      .reset (reset),
      .ctl   (hctl),
      .stat  (hstat)
   );

   tcps_fifo u_low (
      .clock (clock),
      .reset (reset),
      .ctl   (lctl),
      .stat  (lstat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cls_ff       <= CLS_IDLE;
         rem_ff       <= '0;
      end else begin
         req_valid_ff <= start;
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            cls_ff <= cls_in;
            rem_ff <= rem_in;
         end
      end
      if (start) begin
         req_ff <= req;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import tcps_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_ITEMS = 1300;

   class sched_model;
      logic [ID_BITS-1:0]    high_ids   [QUEUE_DEPTH];
      logic [TIME_BITS-1:0]  high_times [QUEUE_DEPTH];
      logic [ID_BITS-1:0]    low_ids    [QUEUE_DEPTH];
      logic [TIME_BITS-1:0]  low_times  [QUEUE_DEPTH];
      logic [IDX_BITS-1:0]   high_head;
      logic [IDX_BITS-1:0]   low_head;
      logic [COUNT_BITS-1:0] high_fill;
      logic [COUNT_BITS-1:0] low_fill;
      logic [TIME_BITS-1:0]  ticks_left;
      cls_type               serving;
      rsp_type               status_due[$];
      int                    mismatch_count;

      function new();
         high_head      = '0;
         low_head       = '0;
         high_fill      = '0;
         low_fill       = '0;
         ticks_left     = '0;
         serving        = CLS_IDLE;
         mismatch_count = 0;
      endfunction

      function void begin_next();
         if (high_fill != 0) begin
            serving    = CLS_HIGH;
            ticks_left = high_times[high_head];
         end else if (low_fill != 0) begin
            serving    = CLS_LOW;
            ticks_left = low_times[low_head];
         end else begin
            serving    = CLS_IDLE;
            ticks_left = '0;
         end
      endfunction

      function void note_request(req_type r);
         rsp_type              e;
         logic [TIME_BITS-1:0] stime;
         logic [IDX_BITS-1:0]  slot;
         e     = '0;
         stime = (r.service_time == '0) ? TIME_BITS'(1) : r.service_time;
         if (r.op == OP_TICK) begin
            if (serving == CLS_HIGH || serving == CLS_LOW) begin
               if (ticks_left <= 1) begin
                  e.done_res = 1'b1;
                  if (serving == CLS_HIGH) begin
                     e.done_high = 1'b1;
                     e.done_id   = high_ids[high_head];
                     high_head   = high_head + 1'b1;
                     high_fill   = high_fill - 1'b1;
                  end else begin
                     e.done_id = low_ids[low_head];
                     low_head  = low_head + 1'b1;
                     low_fill  = low_fill - 1'b1;
                  end
                  begin_next();
               end else begin
                  ticks_left = ticks_left - 1'b1;
               end
            end
         end else if (r.is_high) begin
            if (high_fill >= QUEUE_DEPTH) begin
               e.dropped = 1'b1;
            end else begin
               slot             = high_head + high_fill[IDX_BITS-1:0];
               high_ids[slot]   = r.job_id;
               high_times[slot] = stime;
               high_fill        = high_fill + 1'b1;
               if (serving == CLS_LOW)
                  e.preempted = 1'b1;
               if (serving != CLS_HIGH)
                  begin_next();
            end
         end else begin
            if (low_fill >= QUEUE_DEPTH) begin
               e.dropped = 1'b1;
            end else begin
               slot            = low_head + low_fill[IDX_BITS-1:0];
               low_ids[slot]   = r.job_id;
               low_times[slot] = stime;
               low_fill        = low_fill + 1'b1;
               if (serving != CLS_HIGH && serving != CLS_LOW)
                  begin_next();
            end
         end
         e.serving    = serving;
         e.high_count = high_fill;
         e.low_count  = low_fill;
         status_due.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (status_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected status record %h at %0t", got, $time);
            return;
         end
         want = status_due.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("mismatch at %0t (expected / actual):", $time);
               $display("  done %0d/%0d id %h/%h high %0d/%0d preempted %0d/%0d",
                        want.done_res, got.done_res, want.done_id, got.done_id,
                        want.done_high, got.done_high, want.preempted, got.preempted);
               $display("  dropped %0d/%0d serving %0d/%0d high %0d/%0d low %0d/%0d",
                        want.dropped, got.dropped, want.serving, got.serving,
                        want.high_count, got.high_count, want.low_count, got.low_count);
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   sched_model sched;
   int         idle_pct;
   int         cycle_count = 0;

   two_class_preemptive_scheduler DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sched.check_result(rsp);
   end

   function automatic req_type job(logic high, logic [TIME_BITS-1:0] stime,
                                   logic [ID_BITS-1:0] id);
      req_type r;
      r.op           = OP_ARRIVE;
      r.is_high      = high;
      r.service_time = stime;
      r.job_id       = id;
      return r;
   endfunction

   function automatic req_type tick_req();
      req_type r;
      r.op           = OP_TICK;
      r.is_high      = 1'($urandom);
      r.service_time = TIME_BITS'($urandom);
      r.job_id       = ID_BITS'($urandom);
      return r;
   endfunction

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req   <= r;
      do @(posedge clock); while (busy);
      sched.note_request(r);
   endtask

   initial begin
      int                   arrive_pct;
      int                   high_pct;
      logic [TIME_BITS-1:0] stime;
      sched    = new();
      idle_pct = 17;
      reset <= 1'b1;
      start <= 1'b0;
      req   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: idle tick, zero service time, preemption, queueing behind service
      send_request(tick_req());
      send_request(job(1'b0, 16'h0000, 16'hFFFF));
      send_request(tick_req());
      send_request(job(1'b0, 16'd5, 16'h0000));
      send_request(tick_req());
      send_request(job(1'b1, 16'd2, 16'hA5A5));
      send_request(job(1'b1, 16'd1, 16'h5A5A));
      send_request(job(1'b0, 16'd3, 16'h1234));
      repeat (4) send_request(tick_req());
      // fill the high queue and overflow it
      for (int k = 0; k <= QUEUE_DEPTH; k++)
         send_request(job(1'b1, 16'd1, ID_BITS'(16'hC000 + k)));

      arrive_pct = 50;
      high_pct   = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            case ($urandom_range(2))
               0: arrive_pct = 25;
               1: arrive_pct = 50;
               default: arrive_pct = 80;
            endcase
            case ($urandom_range(2))
               0: high_pct = 15;
               1: high_pct = 50;
               default: high_pct = 85;
            endcase
         end
         idle_pct = (n >= 400 && n < 700) ? 0 : 17;
         if ($urandom_range(99) < arrive_pct) begin
            case ($urandom_range(9))
               0: stime = '0;
               1: stime = TIME_BITS'($urandom_range(5, 24));
               default: stime = TIME_BITS'($urandom_range(1, 4));
            endcase
            send_request(job(1'($urandom_range(99) < high_pct), stime, ID_BITS'($urandom)));
         end else begin
            send_request(tick_req());
         end
      end

      // drain, preempt a low job and let it restart, then end on a full-length job
      idle_pct = 17;
      while (sched.serving != CLS_IDLE)
         send_request(tick_req());
      send_request(job(1'b0, 16'd100, ID_BITS'($urandom)));
      repeat ($urandom_range(20, 60)) send_request(tick_req());
      send_request(job(1'b1, TIME_BITS'($urandom_range(2, 8)), ID_BITS'($urandom)));
      while (sched.serving != CLS_IDLE)
         send_request(tick_req());
      send_request(job(1'b0, 16'hFFFF, ID_BITS'($urandom)));
      repeat (40) send_request(tick_req());

      start <= 1'b0;
      while (sched.status_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (sched.mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/tcps_pkg.sv
hdl/tcps_fifo.sv
hdl/two_class_preemptive_scheduler.sv
tb/sv/testbench.sv
